// ----- design/sdq_pkg.sv -----
// Shared types and constants for the sorted deadline queue.
// Used by sdq_cell and sorted_deadline_queue; no dependencies.
package sdq_pkg;

  localparam int Depth      = 64;
  localparam int MaxRelease = 64;
  localparam int TimeW      = 32;
  localparam int TagW       = 16;
  localparam int LimitW     = 7;
  localparam int FillW      = 7;
  localparam int StatusW    = 2;

  localparam logic [LimitW-1:0] LimitReset = LimitW'(MaxRelease);

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdPop    = 1'b1;

  localparam logic [StatusW-1:0] StInserted = 2'd0;
  localparam logic [StatusW-1:0] StFull     = 2'd1;
  localparam logic [StatusW-1:0] StReleased = 2'd2;
  localparam logic [StatusW-1:0] StNoneDue  = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [TimeW-1:0] due_time;
    logic [TagW-1:0]  tag;
  } sdq_entry_t;

  typedef struct packed {
    logic             ins;
    logic             shift;
    logic [TimeW-1:0] new_time;
    logic [TagW-1:0]  new_tag;
  } sdq_ctl_t;

endpackage

// ----- design/sdq_cell.sv -----
// One storage cell of the sorted deadline queue chain.
// Depends on sdq_pkg for the entry and control structs.
module sdq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sdq_pkg::sdq_ctl_t  ctl_i,
  input  sdq_pkg::sdq_entry_t prev_i,
  input  logic               prev_after_i,
  input  sdq_pkg::sdq_entry_t next_i,
  output sdq_pkg::sdq_entry_t entry_o,
  output logic               after_o
);

  logic                         valid_q, valid_d;
  logic [sdq_pkg::TimeW-1:0]    time_q, time_d;
  logic [sdq_pkg::TagW-1:0]     tag_q, tag_d;
  logic                         own_after;

  assign own_after = valid_q && (time_q > ctl_i.new_time);
  assign after_o   = own_after;

  always_comb begin
    valid_d = valid_q;
    time_d  = time_q;
    tag_d   = tag_q;
    if (ctl_i.ins) begin
      if (prev_after_i) begin
        valid_d = prev_i.valid;
        time_d  = prev_i.due_time;
        tag_d   = prev_i.tag;
      end else if ((!valid_q && prev_i.valid) || own_after) begin
        valid_d = 1'b1;
        time_d  = ctl_i.new_time;
        tag_d   = ctl_i.new_tag;
      end
    end else if (ctl_i.shift) begin
      valid_d = next_i.valid;
      time_d  = next_i.due_time;
      tag_d   = next_i.tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    tag_q  <= tag_d;
  end

  assign entry_o = '{valid: valid_q, due_time: time_q, tag: tag_q};

endmodule

// ----- design/sorted_deadline_queue.sv -----
// Top level of the sorted deadline queue: a chain of sdq_cell entries kept
// sorted by due time, with the insert/pop sequencer and the output register.
// Depends on sdq_pkg and sdq_cell.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o): one beat per command. An insert
//   places (time, tag) behind every stored entry due at or before it and
//   returns one beat: inserted, or full and dropped.
//   A pop releases head entries due at or before its time, one beat per
//   cycle through the head cell while the receiver does not stall, up to
//   pop_limit (at most 64), the final one with is_last. With nothing due it
//   returns a single nothing-due beat.
//   Output channel (out_valid_o / out_stall_i): one registered result slot.
//   An insert result is registered from the accepted input beat; a pop first
//   latches its time, then releases entries through the single head read
//   port, and no new input beat is taken until the pop is done.
//   Config channel (cfg_valid_i / cfg_ready_o): pop_limit, always ready.
//   Reset empties the queue and sets pop_limit to 64. While the receiver
//   stalls, the result slot holds and no new input beat is taken.
module sorted_deadline_queue #(
  parameter int DEPTH = sdq_pkg::Depth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic [sdq_pkg::TimeW-1:0]    time_value_i,
  input  logic [sdq_pkg::TagW-1:0]     entry_tag_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sdq_pkg::TagW-1:0]     out_tag_o,
  output logic [sdq_pkg::TimeW-1:0]    out_time_o,
  output logic [sdq_pkg::StatusW-1:0]  status_o,
  output logic                         is_last_o,
  output logic [sdq_pkg::FillW-1:0]    fill_level_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sdq_pkg::LimitW-1:0]   cfg_data_i
);

  localparam int CountW = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_e;

  state_e                          state_q;
  logic [CountW-1:0]               count_q;
  logic [sdq_pkg::LimitW-1:0]      limit_q;
  logic [sdq_pkg::LimitW-1:0]      taken_q;
  logic [sdq_pkg::TimeW-1:0]       pop_time_q;
  logic                            out_valid_q;
  logic [sdq_pkg::TagW-1:0]        out_tag_q;
  logic [sdq_pkg::TimeW-1:0]       out_time_q;
  logic [sdq_pkg::StatusW-1:0]     status_q;
  logic                            is_last_q;
  logic [sdq_pkg::FillW-1:0]       fill_q;

  sdq_pkg::sdq_entry_t             entries [DEPTH];
  logic                            after   [DEPTH];
  sdq_pkg::sdq_ctl_t               ctl;

  logic                            out_free;
  logic                            in_acc;
  logic                            ins_go;
  logic                            pop_go;
  logic                            elig;
  logic                            last_rel;
  logic                            is_full;
  logic [sdq_pkg::LimitW-1:0]      lim_eff;
  logic [sdq_pkg::LimitW-1:0]      taken_inc;
  logic [CountW-1:0]               count_inc;
  logic [CountW-1:0]               count_dec;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_full    = (count_q >= CountW'(DEPTH));
  assign ins_go     = in_acc && (cmd_i == sdq_pkg::CmdInsert) && !is_full;

  assign lim_eff   = (limit_q > sdq_pkg::LimitW'(sdq_pkg::MaxRelease))
                     ? sdq_pkg::LimitW'(sdq_pkg::MaxRelease) : limit_q;
  assign taken_inc = taken_q + sdq_pkg::LimitW'(1);
  assign count_inc = count_q + CountW'(1);
  assign count_dec = count_q - CountW'(1);

  assign elig     = (taken_q < lim_eff) && entries[0].valid
                    && (entries[0].due_time <= pop_time_q);
  assign last_rel = (taken_inc == lim_eff) || !entries[1].valid
                    || (entries[1].due_time > pop_time_q);
  assign pop_go   = (state_q == ST_POP) && out_free && elig;

  assign ctl = '{ins: ins_go, shift: pop_go, new_time: time_value_i,
                 new_tag: entry_tag_i};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sdq_pkg::sdq_entry_t prev_e, next_e;
    logic                prev_a;
    if (i == 0) begin : g_head
      assign prev_e = '{valid: 1'b1, due_time: '0, tag: '0};
      assign prev_a = 1'b0;
    end else begin : g_body
      assign prev_e = entries[i-1];
      assign prev_a = after[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = entries[i+1];
    end
    sdq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .prev_i       (prev_e),
      .prev_after_i (prev_a),
      .next_i       (next_e),
      .entry_o      (entries[i]),
      .after_o      (after[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      limit_q     <= sdq_pkg::LimitReset;
      taken_q     <= '0;
      pop_time_q  <= '0;
      out_valid_q <= 1'b0;
      out_tag_q   <= '0;
      out_time_q  <= '0;
      status_q    <= sdq_pkg::StInserted;
      is_last_q   <= 1'b0;
      fill_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (in_acc) begin
        if (cmd_i == sdq_pkg::CmdInsert) begin
          out_valid_q <= 1'b1;
          is_last_q   <= 1'b1;
          out_tag_q   <= '0;
          out_time_q  <= '0;
          if (is_full) begin
            status_q <= sdq_pkg::StFull;
            fill_q   <= sdq_pkg::FillW'(count_q);
          end else begin
            status_q <= sdq_pkg::StInserted;
            fill_q   <= sdq_pkg::FillW'(count_inc);
            count_q  <= count_inc;
          end
        end else begin
          out_valid_q <= 1'b0;
          state_q     <= ST_POP;
          pop_time_q  <= time_value_i;
          taken_q     <= '0;
        end
      end else if (state_q == ST_POP && out_free) begin
        out_valid_q <= 1'b1;
        if (elig) begin
          out_tag_q  <= entries[0].tag;
          out_time_q <= entries[0].due_time;
          status_q   <= sdq_pkg::StReleased;
          is_last_q  <= last_rel;
          fill_q     <= sdq_pkg::FillW'(count_dec);
          count_q    <= count_dec;
          taken_q    <= taken_inc;
          if (last_rel) begin
            state_q <= ST_IDLE;
          end
        end else begin
          out_tag_q  <= '0;
          out_time_q <= '0;
          status_q   <= sdq_pkg::StNoneDue;
          is_last_q  <= 1'b1;
          fill_q     <= sdq_pkg::FillW'(count_q);
          state_q    <= ST_IDLE;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign out_tag_o    = out_tag_q;
  assign out_time_o   = out_time_q;
  assign status_o     = status_q;
  assign is_last_o    = is_last_q;
  assign fill_level_o = fill_q;

endmodule

// ----- dv/deadline_order_checker.sv -----
`timescale 1ns / 100ps
// Result checker for sorted_deadline_queue: tracks queue contents and pop_limit
// from accepted beats and compares every result beat in arrival order.
// Depends on sdq_pkg.
module deadline_order_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic [sdq_pkg::TimeW-1:0]    time_value_i,
  input  logic [sdq_pkg::TagW-1:0]     entry_tag_i,
  input  logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  logic [sdq_pkg::TagW-1:0]     out_tag_o,
  input  logic [sdq_pkg::TimeW-1:0]    out_time_o,
  input  logic [sdq_pkg::StatusW-1:0]  status_o,
  input  logic                         is_last_o,
  input  logic [sdq_pkg::FillW-1:0]    fill_level_o,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_o,
  input  logic [sdq_pkg::LimitW-1:0]   cfg_data_i,
  output int                           errors_o,
  output int                           pending_o,
  output int                           beats_o
);

  typedef struct packed {
    logic [sdq_pkg::TagW-1:0]    tag;
    logic [sdq_pkg::TimeW-1:0]   due;
    logic [sdq_pkg::StatusW-1:0] status;
    logic                        last;
    logic [sdq_pkg::FillW-1:0]   fill;
  } result_beat_t;

  logic [sdq_pkg::TimeW-1:0]  held_time [sdq_pkg::Depth];
  logic [sdq_pkg::TagW-1:0]   held_tag  [sdq_pkg::Depth];
  int unsigned                held_count;
  logic [sdq_pkg::LimitW-1:0] release_limit;
  result_beat_t               awaited_q [$];
  result_beat_t               want;
  int                         errors = 0;
  int                         beats = 0;

  function automatic void note_beat(logic [sdq_pkg::TagW-1:0] tag,
                                    logic [sdq_pkg::TimeW-1:0] due,
                                    logic [sdq_pkg::StatusW-1:0] status, logic last);
    result_beat_t b;
    b.tag    = tag;
    b.due    = due;
    b.status = status;
    b.last   = last;
    b.fill   = sdq_pkg::FillW'(held_count);
    awaited_q.push_back(b);
  endfunction

  function automatic void predict_command(logic cmd, logic [sdq_pkg::TimeW-1:0] tv,
                                          logic [sdq_pkg::TagW-1:0] tag);
    int unsigned slot, take, lim, i;
    if (cmd == sdq_pkg::CmdInsert) begin
      if (held_count >= sdq_pkg::Depth) begin
        note_beat('0, '0, sdq_pkg::StFull, 1'b1);
        return;
      end
      slot = 0;
      while (slot < held_count && held_time[slot] <= tv) slot++;
      for (i = held_count; i > slot; i--) begin
        held_time[i] = held_time[i-1];
        held_tag[i]  = held_tag[i-1];
      end
      held_time[slot] = tv;
      held_tag[slot]  = tag;
      held_count++;
      note_beat('0, '0, sdq_pkg::StInserted, 1'b1);
    end else begin
      lim  = (release_limit > sdq_pkg::MaxRelease) ? sdq_pkg::MaxRelease : release_limit;
      take = 0;
      while (take < lim && take < held_count && held_time[take] <= tv) take++;
      if (take == 0) begin
        note_beat('0, '0, sdq_pkg::StNoneDue, 1'b1);
        return;
      end
      for (i = 0; i < take; i++) begin
        held_count--;
        note_beat(held_tag[i], held_time[i], sdq_pkg::StReleased, i + 1 == take);
      end
      for (i = 0; i < held_count; i++) begin
        held_time[i] = held_time[i + take];
        held_tag[i]  = held_tag[i + take];
      end
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count    = 0;
      release_limit = sdq_pkg::LimitReset;
      awaited_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) release_limit = cfg_data_i;
      if (in_valid_i && !in_stall_o) predict_command(cmd_i, time_value_i, entry_tag_i);
      if (out_valid_o && !out_stall_i) begin
        beats++;
        if (awaited_q.size() == 0) begin
          $display("%0t: result beat with none pending, status %0d tag %0h time %0h",
                   $time, status_o, out_tag_o, out_time_o);
          errors++;
        end else begin
          want = awaited_q.pop_front();
          check_field("out_tag", 32'(want.tag), 32'(out_tag_o));
          check_field("out_time", want.due, out_time_o);
          check_field("status", 32'(want.status), 32'(status_o));
          check_field("is_last", 32'(want.last), 32'(is_last_o));
          check_field("fill_level", 32'(want.fill), 32'(fill_level_o));
        end
      end
    end
    errors_o  <= errors;
    pending_o <= awaited_q.size();
    beats_o   <= beats;
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Top of the sorted_deadline_queue testbench: clock, reset, insert/pop and
// pop_limit stimulus, receiver stalls and the verdict.
// Depends on sdq_pkg, sorted_deadline_queue and deadline_order_checker.
module testbench;

  localparam int CycleLimit = 600000;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic                        cmd_i = sdq_pkg::CmdInsert;
  logic [sdq_pkg::TimeW-1:0]   time_value_i = '0;
  logic [sdq_pkg::TagW-1:0]    entry_tag_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [sdq_pkg::TagW-1:0]    out_tag_o;
  logic [sdq_pkg::TimeW-1:0]   out_time_o;
  logic [sdq_pkg::StatusW-1:0] status_o;
  logic                        is_last_o;
  logic [sdq_pkg::FillW-1:0]   fill_level_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [sdq_pkg::LimitW-1:0]  cfg_data_i = '0;

  int errors, pending, beats;
  int cycle_count = 0;
  int sent = 0;
  int limits_set = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  logic [sdq_pkg::TimeW-1:0] now_base = 32'd1000;

  sorted_deadline_queue uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .time_value_i(time_value_i),
    .entry_tag_i (entry_tag_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_tag_o   (out_tag_o),
    .out_time_o  (out_time_o),
    .status_o    (status_o),
    .is_last_o   (is_last_o),
    .fill_level_o(fill_level_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  deadline_order_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .time_value_i(time_value_i),
    .entry_tag_i (entry_tag_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_tag_o   (out_tag_o),
    .out_time_o  (out_time_o),
    .status_o    (status_o),
    .is_last_o   (is_last_o),
    .fill_level_o(fill_level_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending),
    .beats_o     (beats)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d beats still pending", cycle_count, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_cmd(logic cmd, logic [sdq_pkg::TimeW-1:0] tv,
                          logic [sdq_pkg::TagW-1:0] tag);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    time_value_i <= tv;
    entry_tag_i  <= tag;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [sdq_pkg::LimitW-1:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limits_set++;
  endtask

  function automatic logic [sdq_pkg::TimeW-1:0] due_time();
    if ($urandom_range(1, 100) <= 15) return $urandom;
    return now_base + $urandom_range(0, 300);
  endfunction

  function automatic logic [sdq_pkg::TimeW-1:0] pop_time();
    int r;
    r = $urandom_range(1, 100);
    if (r <= 8) return '0;
    if (r <= 18) return '1;
    if (r <= 24) return $urandom;
    now_base = now_base + $urandom_range(0, 120);
    return now_base + $urandom_range(0, 200);
  endfunction

  task automatic run_phase(int count, int pop_pct);
    repeat (count) begin
      if ($urandom_range(1, 100) <= pop_pct)
        send_cmd(sdq_pkg::CmdPop, pop_time(), 16'($urandom_range(0, 65535)));
      else
        send_cmd(sdq_pkg::CmdInsert, due_time(), 16'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    logic [sdq_pkg::LimitW-1:0] limit_plan [9];
    limit_plan = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd65, 7'd0, 7'd64, 7'd0, 7'd0};
    limit_plan[5] = 7'($urandom_range(1, 64));
    limit_plan[7] = 7'($urandom_range(1, 64));
    limit_plan[8] = 7'($urandom_range(1, 64));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pops, extreme times and tags, equal times kept in arrival order
    gap_pct   = 30;
    stall_pct = 10;
    send_cmd(sdq_pkg::CmdPop, '0, '0);
    send_cmd(sdq_pkg::CmdPop, '1, '1);
    send_cmd(sdq_pkg::CmdInsert, 32'd100, 16'h0001);
    send_cmd(sdq_pkg::CmdInsert, 32'd100, 16'h0002);
    send_cmd(sdq_pkg::CmdInsert, '0, '1);
    send_cmd(sdq_pkg::CmdInsert, '1, '0);
    send_cmd(sdq_pkg::CmdInsert, 32'd50, 16'hAAAA);
    send_cmd(sdq_pkg::CmdInsert, 32'd100, 16'h0003);
    send_cmd(sdq_pkg::CmdPop, '0, '0);
    send_cmd(sdq_pkg::CmdPop, 32'd99, '0);
    send_cmd(sdq_pkg::CmdPop, 32'd100, '0);
    send_cmd(sdq_pkg::CmdPop, 32'hFFFF_FFFE, '0);
    send_cmd(sdq_pkg::CmdPop, '1, '0);

    // pop_limit of zero releases nothing
    write_limit(7'd0);
    send_cmd(sdq_pkg::CmdInsert, 32'd5, 16'h5555);
    send_cmd(sdq_pkg::CmdPop, '1, '0);
    write_limit(7'd1);
    send_cmd(sdq_pkg::CmdInsert, 32'd5, 16'h6666);
    send_cmd(sdq_pkg::CmdPop, '1, '0);
    send_cmd(sdq_pkg::CmdPop, '1, '0);
    write_limit(7'd127);
    send_cmd(sdq_pkg::CmdInsert, 32'h8000_0000, 16'h1234);
    send_cmd(sdq_pkg::CmdInsert, 32'h7FFF_FFFF, 16'hEDCB);
    send_cmd(sdq_pkg::CmdInsert, 32'h8000_0000, 16'h5A5A);
    send_cmd(sdq_pkg::CmdPop, '1, '0);

    // fill past capacity, then release a full batch
    write_limit(7'd64);
    gap_pct   = 20;
    stall_pct = 5;
    repeat (66) send_cmd(sdq_pkg::CmdInsert, due_time(), 16'($urandom_range(0, 65535)));
    send_cmd(sdq_pkg::CmdPop, '1, '0);
    send_cmd(sdq_pkg::CmdPop, '1, '0);

    foreach (limit_plan[p]) begin
      write_limit(limit_plan[p]);
      if (p == 8) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = (p % 3 == 0) ? 0 : $urandom_range(10, 40);
        stall_pct = (p % 3 == 1) ? 0 : $urandom_range(3, 15);
      end
      run_phase(32, (p % 2 == 0) ? 30 : 50);
    end

    settle();
    repeat (16) @(posedge clk_i);
    $display("Sent %0d commands under %0d pop_limit writes; checked %0d result beats",
             sent, limits_set, beats);
    $display("Covered empty and full queues, equal due times, limits 0, 1, 64 and above 64");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/sdq_pkg.sv
design/sdq_cell.sv
design/sorted_deadline_queue.sv
dv/deadline_order_checker.sv
dv/testbench.sv
